// ===== sv/vsfn_pkg.sv =====
// ----------------------------------------------------------------------------
// vsfn_pkg
// Types, constants and status update function shared by the virtio status
// and feature negotiation block.
// ----------------------------------------------------------------------------
`default_nettype none

package vsfn_pkg;

    localparam int unsigned STATUS_W   = 8;
    localparam int unsigned FEAT_W     = 64;
    localparam int unsigned HALF_W     = 32;
    localparam int unsigned SEL_W      = 2;
    localparam int unsigned IN_DATA_W  = 48;
    localparam int unsigned OUT_DATA_W = 80;
    localparam int unsigned CFG_IDX_W  = 1;

    localparam logic [STATUS_W-1:0] ST_ACK         = 8'h01;
    localparam logic [STATUS_W-1:0] ST_DRIVER      = 8'h02;
    localparam logic [STATUS_W-1:0] ST_DRIVER_OK   = 8'h04;
    localparam logic [STATUS_W-1:0] ST_FEATURES_OK = 8'h08;
    localparam logic [STATUS_W-1:0] ST_FAILED      = 8'h80;
    localparam logic [STATUS_W-1:0] ST_KEEP_MASK   =
        ST_ACK | ST_DRIVER | ST_DRIVER_OK | ST_FEATURES_OK | ST_FAILED;

    localparam logic [FEAT_W-1:0] FEAT_VERSION_1 = 64'h0000_0001_0000_0000;

    localparam logic [SEL_W-1:0] SEL_LOW  = 2'd0;
    localparam logic [SEL_W-1:0] SEL_HIGH = 2'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_FEATURES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ACTIVE   = 1'd1;

    typedef enum logic
    {
        MODE_STATUS  = 1'b0,
        MODE_FEATURE = 1'b1
    } mode_t;

    typedef struct packed
    {
        mode_t             mode;
        logic [7:0]        status_byte;
        logic [SEL_W-1:0]  feature_select;
        logic [HALF_W-1:0] feature_word;
    } item_t;

    typedef struct packed
    {
        logic [STATUS_W-1:0] device_status;
        logic [FEAT_W-1:0]   accepted_features;
        logic                reset_request;
        logic                write_ignored;
    } result_t;

    function automatic logic [STATUS_W-1:0] apply_status(
        input logic [STATUS_W-1:0] written,
        input logic [STATUS_W-1:0] stored,
        input logic [FEAT_W-1:0]   drv_feat,
        input logic [FEAT_W-1:0]   dev_feat
    );
        logic [STATUS_W-1:0] s;
        logic [FEAT_W-1:0]   offered;
        s       = (written & ST_KEEP_MASK) | stored;
        offered = dev_feat | FEAT_VERSION_1;
        if ((s & ST_ACK) == '0)
            s = s & ~(ST_DRIVER | ST_FEATURES_OK | ST_DRIVER_OK);
        if ((s & ST_DRIVER) == '0)
            s = s & ~(ST_FEATURES_OK | ST_DRIVER_OK);
        if (((s & ST_FEATURES_OK) != '0) && ((stored & ST_FEATURES_OK) == '0))
        begin
            if (((drv_feat & FEAT_VERSION_1) == '0) || ((drv_feat & ~offered) != '0))
                s = s & ~ST_FEATURES_OK;
        end
        if ((s & ST_FEATURES_OK) == '0)
            s = s & ~ST_DRIVER_OK;
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== sv/vsfn_core.sv =====
// ----------------------------------------------------------------------------
// vsfn_core
// Negotiation state, configuration registers and result register. One
// registered item is applied to the state per advance.
// ----------------------------------------------------------------------------
`default_nettype none

module vsfn_core
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [vsfn_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [vsfn_pkg::FEAT_W-1:0]       cfg_data,
    input  wire logic                              advance,
    input  wire vsfn_pkg::item_t                   item,
    output vsfn_pkg::result_t                      result
);

    logic [vsfn_pkg::FEAT_W-1:0]   dev_feat_reg;
    logic                          dev_active_reg;
    logic [vsfn_pkg::STATUS_W-1:0] status_reg,   status_next;
    logic [vsfn_pkg::FEAT_W-1:0]   drv_feat_reg, drv_feat_next;
    vsfn_pkg::result_t             result_reg,   result_next;
    logic                          ignored;

    always_comb
    begin
        status_next   = status_reg;
        drv_feat_next = drv_feat_reg;
        ignored       = 1'b0;
        if (item.mode == vsfn_pkg::MODE_STATUS)
        begin
            if (item.status_byte == '0)
            begin
                status_next   = '0;
                drv_feat_next = '0;
            end
            else
            begin
                status_next = vsfn_pkg::apply_status(item.status_byte, status_reg,
                                                     drv_feat_reg, dev_feat_reg);
            end
        end
        else
        begin
            if (!dev_active_reg || ((status_reg & vsfn_pkg::ST_FEATURES_OK) != '0) ||
                (item.feature_select != vsfn_pkg::SEL_LOW &&
                 item.feature_select != vsfn_pkg::SEL_HIGH))
                ignored = 1'b1;
            else if (item.feature_select == vsfn_pkg::SEL_LOW)
                drv_feat_next = {drv_feat_reg[63:32], item.feature_word};
            else
                drv_feat_next = {item.feature_word, drv_feat_reg[31:0]};
        end
        result_next.device_status     = status_next;
        result_next.accepted_features = drv_feat_next;
        result_next.reset_request     = (item.mode == vsfn_pkg::MODE_STATUS) &&
                                        (item.status_byte == '0);
        result_next.write_ignored     = ignored;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_feat_reg   <= '0;
            dev_active_reg <= 1'b1;
            status_reg     <= '0;
            drv_feat_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    vsfn_pkg::CFG_DEVICE_FEATURES: dev_feat_reg   <= cfg_data;
                    vsfn_pkg::CFG_DEVICE_ACTIVE:   dev_active_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (advance)
            begin
                status_reg   <= status_next;
                drv_feat_reg <= drv_feat_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// ===== sv/virtio_status_feature_negotiation.sv =====
// ----------------------------------------------------------------------------
// virtio_status_feature_negotiation
// Virtio device status and driver feature registers behind a stream port.
// ----------------------------------------------------------------------------
// Each slave transfer is one driver access: tuser selects a status write (0)
// or a driver feature half write (1). Each access yields exactly one master
// transfer carrying the stored status, the stored driver features and the
// reset and ignored flags after that access.
// The access is captured in an input register, applied to the state when
// the output register is free or being read, and its result placed in that
// output register, which drives master tvalid. One access is taken every
// cycle while the receiver does not stall; the status/feature update is a
// combinational step between the two registers.
// If the receiver stalls, the output register holds its result and the input
// register holds one more access; s_tready drops only while both are full and
// m_tready is low.
// Reset clears status and driver features, device_features to zero and
// device_active to one, and empties both registers.
// Configuration writes (cfg_we) take effect at the next edge and are
// expected only while no access is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module virtio_status_feature_negotiation
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [vsfn_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [vsfn_pkg::FEAT_W-1:0]        cfg_data,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [7:0] status_byte, [9:8] feature_select, [41:10] feature_word
    input  wire logic [vsfn_pkg::IN_DATA_W-1:0]     s_tdata,
    // [0] mode
    input  wire logic                               s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [7:0] device_status, [71:8] accepted_features, [72] reset_request,
    // [73] write_ignored
    output logic [vsfn_pkg::OUT_DATA_W-1:0]         m_tdata
);

    logic              in_valid_reg;
    logic              out_valid_reg;
    vsfn_pkg::item_t   item_reg;
    vsfn_pkg::result_t result;
    logic              advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.mode           <= vsfn_pkg::mode_t'(s_tuser);
            item_reg.status_byte    <= s_tdata[7:0];
            item_reg.feature_select <= s_tdata[9:8];
            item_reg.feature_word   <= s_tdata[41:10];
        end
    end

    vsfn_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .item      (item_reg),
        .result    (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, result.write_ignored, result.reset_request,
                       result.accepted_features, result.device_status};

    a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled while output register empty");

    a_reset_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result.reset_request) |->
            (result.device_status == '0 && result.accepted_features == '0))
        else $error("reset request with state not cleared");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(result.reset_request && result.write_ignored))
        else $error("reset request and ignored write together");

    a_driver_ok_needs_features_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (result.device_status & vsfn_pkg::ST_DRIVER_OK) != '0) |->
            ((result.device_status & vsfn_pkg::ST_FEATURES_OK) != '0))
        else $error("DRIVER_OK without FEATURES_OK");

endmodule

`default_nettype wire
